FILE: hw/rtl/cfs_pkg.sv
// ============================================================================
// cfs_pkg
// Shared types and constants for the circular FIFO with content search.
// ============================================================================
package cfs_pkg;

    // Fixed field widths of the stream payloads.
    localparam int WORD_W      = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 3;
    localparam int COUNT_OUT_W = 4;
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = OP_W;
    localparam int OUT_DATA_W  = 80;

    // Default queue depth.
    localparam int DEF_DEPTH = 8;

    // Operation codes carried on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch operation and word from the input transfer
        logic exec;       // apply the operation to pointers, fill and store
        logic head_load;  // take the store read data as the new front word
        logic scan_step;  // compare one store entry and advance the scan
        logic out_load;   // move the finished result into the output register
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic deq_needs_read;    // dequeue leaves entries, front word must be read
        logic search_needs_scan; // search on a non-empty queue
        logic scan_done;         // match found or last live entry compared
        logic out_free;          // output register can take a result this cycle
    } t_dp_stat;

endpackage

FILE: hw/rtl/cfs_ctrl.sv
// ============================================================================
// cfs_ctrl
// Sequencer for one operation at a time: capture, execute, optional front
// word read or search scan, then hand-off to the output register.
// ============================================================================
module cfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cfs_pkg::t_dp_stat i_stat,
    output cfs_pkg::t_dp_cmd  o_cmd
);
    import cfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HEAD_RD,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.deq_needs_read) begin
                    n_state = S_HEAD_RD;
                end else if (i_stat.search_needs_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_HEAD_RD: n_state = S_FINISH;
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec      = (r_state == S_EXEC);
    assign o_cmd.head_load = (r_state == S_HEAD_RD);
    assign o_cmd.scan_step = (r_state == S_SCAN);
    assign o_cmd.out_load  = (r_state == S_FINISH) && i_stat.out_free;

endmodule

FILE: hw/rtl/cfs_datapath.sv
// ============================================================================
// cfs_datapath
// Word store, ring pointers, fill count, cached front and rear words,
// search scan registers and the output register.
// ============================================================================
module cfs_datapath #(
    parameter int DEPTH = cfs_pkg::DEF_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cfs_pkg::t_dp_cmd                i_cmd,
    output cfs_pkg::t_dp_stat               o_stat,
    input  logic [cfs_pkg::IN_USER_W-1:0]   i_op,
    input  logic [cfs_pkg::WORD_W-1:0]      i_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cfs_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import cfs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
    localparam int PAD_W = OUT_DATA_W - (STATUS_W + 1 + SLOT_OUT_W + 2 * WORD_W
                                         + COUNT_OUT_W + 2);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    logic [WORD_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_fill;
    logic [WORD_W-1:0] r_head_word;
    logic [WORD_W-1:0] r_tail_word;
    t_op               r_op;
    logic [WORD_W-1:0] r_key;
    t_status           r_status;
    logic              r_found;
    logic [PTR_W-1:0]  r_found_slot;
    logic [PTR_W-1:0]  r_scan_ptr;
    logic [CNT_W-1:0]  r_scan_left;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic              is_empty;
    logic              is_full;
    logic              match;
    logic              last_entry;

    assign is_empty   = (r_fill == '0);
    assign is_full    = (r_fill == FULL_CNT);
    assign match      = (r_rd_data == r_key);
    assign last_entry = (r_scan_left == ONE_CNT);

    assign o_stat.deq_needs_read    = (r_op == OP_DEQ) && (r_fill > ONE_CNT);
    assign o_stat.search_needs_scan = (r_op == OP_SEARCH) && !is_empty;
    assign o_stat.scan_done         = match || last_entry;
    assign o_stat.out_free          = !r_out_valid || i_out_ready;

    // Store port control.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = next_slot(r_tail);
        rd_en   = 1'b0;
        rd_addr = r_head;
        if (i_cmd.exec) begin
            unique case (r_op)
                OP_ENQ:    wr_en = !is_full;
                OP_DEQ: begin
                    rd_en   = (r_fill > ONE_CNT);
                    rd_addr = next_slot(r_head);
                end
                OP_SEARCH: rd_en = !is_empty;
                default:   ;
            endcase
        end else if (i_cmd.scan_step && !match && !last_entry) begin
            rd_en   = 1'b1;
            rd_addr = next_slot(r_scan_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= r_key;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    // Queue state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= LAST_SLOT;
            r_fill <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_ENQ: begin
                    if (!is_full) begin
                        r_tail <= next_slot(r_tail);
                        r_fill <= r_fill + ONE_CNT;
                    end
                end
                OP_DEQ: begin
                    if (!is_empty) begin
                        r_head <= next_slot(r_head);
                        r_fill <= r_fill - ONE_CNT;
                    end
                end
                default: ;
            endcase
        end
    end

    // Operation payload, cached words and scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_op);
            r_key <= i_word;
        end
        if (i_cmd.exec) begin
            r_found      <= 1'b0;
            r_found_slot <= '0;
            r_scan_ptr   <= r_head;
            r_scan_left  <= r_fill;
            unique case (r_op)
                OP_ENQ: begin
                    if (is_full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status    <= ST_DONE;
                        r_tail_word <= r_key;
                        if (is_empty) r_head_word <= r_key;
                    end
                end
                OP_DEQ: begin
                    r_status <= is_empty ? ST_EMPTY : ST_DONE;
                end
                default: r_status <= ST_DONE;
            endcase
        end
        if (i_cmd.head_load) r_head_word <= r_rd_data;
        if (i_cmd.scan_step) begin
            if (match) begin
                r_found      <= 1'b1;
                r_found_slot <= r_scan_ptr;
            end else if (!last_entry) begin
                r_scan_ptr  <= next_slot(r_scan_ptr);
                r_scan_left <= r_scan_left - ONE_CNT;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {
                {PAD_W{1'b0}},
                is_full,
                is_empty,
                COUNT_OUT_W'(r_fill),
                (is_empty ? '0 : r_tail_word),
                (is_empty ? '0 : r_head_word),
                SLOT_OUT_W'(r_found_slot),
                r_found,
                r_status
            };
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hw/rtl/circular_fifo_with_search.sv
// ============================================================================
// circular_fifo_with_search
// Fixed-depth ring FIFO of 32-bit words with an in-order content search.
// ============================================================================
// Usage:
//   Each transfer on the s_axis channel carries one operation in tuser
//   (enqueue, dequeue or search) and a word in tdata. For every input
//   transfer exactly one result transfer leaves on m_axis, holding the
//   status, the search outcome, the front and rear words, the fill count
//   and the empty and full flags as they stand after the operation.
//   Operations are handled one at a time. Enqueue, rejected operations and
//   unknown codes pass through the execute and finish states to a loaded
//   result; dequeue that leaves entries adds a front-word read state, because
//   the new front word is fetched through the single store read port. Search
//   of a non-empty queue adds a scan state comparing the live entries, at most
//   DEPTH, until a match; the scan walks the store one entry per cycle from the
//   front. The next input is taken in the cycle after the result is loaded.
//   The result sits in an output register, so a new operation is accepted
//   and worked on while an earlier result still waits; if the receiver
//   stalls, the sequencer holds the finished result until the register
//   frees and s_axis_tready stays low meanwhile.
//   Synchronous reset empties the queue (front slot 0, rear slot
//   DEPTH-1, count 0) and drops any pending result. Store contents are not
//   cleared; a slot is never read before it is written.
// ============================================================================
module circular_fifo_with_search #(
    parameter int DEPTH = cfs_pkg::DEF_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] value
    input  logic [cfs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [cfs_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] status, [2] found, [5:3] found_slot, [37:6] head_value,
    // [69:38] tail_value, [73:70] count, [74] is_empty, [75] is_full,
    // [79:76] zero
    output logic [cfs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import cfs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer: one operation in flight, stepping the datapath.
    cfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Store, pointers, scan logic and the output register.
    cfs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (s_axis_tuser),
        .i_word      (s_axis_tdata[WORD_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for circular_fifo_with_search. Each transfer sent on
// s_axis is run through a behavioral copy of the ring and its search, and
// the expected report is queued. Every report that leaves m_axis is compared
// field by field with the oldest queued one. Both sides insert random gaps,
// and the receiver holds off once for a long stretch.
// ============================================================================
module testbench;

    import cfs_pkg::*;

    localparam int          DEPTH       = DEF_DEPTH;
    localparam logic [1:0]  OP_UNKNOWN  = 2'd3;
    localparam int          STALL_LIMIT = 3000;
    localparam int          DRAIN_TAIL  = 20;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [2:0]  slot;
        logic [31:0] head_word;
        logic [31:0] tail_word;
        logic [3:0]  count;
        logic        empty;
        logic        full;
    } t_fifo_report;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [31:0] value
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [1:0] operation
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] status, [2] found, [5:3] found_slot, [37:6] head_value,
    // [69:38] tail_value, [73:70] count, [74] is_empty, [75] is_full,
    // [79:76] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Behavioral copy of the ring.
    logic [31:0] ring_word [DEPTH];
    logic [2:0]  ring_head;
    logic [2:0]  ring_tail;
    logic [3:0]  ring_fill;

    t_fifo_report report_q[$];
    int           mismatch_count = 0;
    int           stall_cycles   = 0;
    int           hold_off_len   = 0;
    bit           no_idle        = 1'b0;

    circular_fifo_with_search #(.DEPTH(DEPTH)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [2:0] next_slot(logic [2:0] p);
        return (p == 3'(DEPTH - 1)) ? 3'd0 : p + 3'd1;
    endfunction

    // Applies one operation to the ring copy and returns the report it gives.
    function automatic t_fifo_report ring_apply(logic [1:0] op, logic [31:0] word);
        t_fifo_report r;
        logic [2:0]   p;
        r = '0;
        case (op)
            OP_ENQ: begin
                if (ring_fill >= 4'(DEPTH)) begin
                    r.status = ST_FULL;
                end else begin
                    ring_tail = next_slot(ring_tail);
                    ring_word[ring_tail] = word;
                    ring_fill++;
                end
            end
            OP_DEQ: begin
                if (ring_fill == 4'd0) begin
                    r.status = ST_EMPTY;
                end else begin
                    ring_head = next_slot(ring_head);
                    ring_fill--;
                end
            end
            OP_SEARCH: begin
                p = ring_head;
                for (int i = 0; i < ring_fill; i++) begin
                    if (!r.found && ring_word[p] == word) begin
                        r.found = 1'b1;
                        r.slot  = p;
                    end
                    p = next_slot(p);
                end
            end
            default: ;
        endcase
        if (ring_fill != 4'd0) begin
            r.head_word = ring_word[ring_head];
            r.tail_word = ring_word[ring_tail];
        end
        r.count = ring_fill;
        r.empty = (ring_fill == 4'd0);
        r.full  = (ring_fill >= 4'(DEPTH));
        return r;
    endfunction

    // Offers one item after a random gap and predicts it once it transfers.
    task automatic send_item(input logic [1:0] op, input logic [31:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        report_q.push_back(ring_apply(op, word));
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    task automatic check_report(input logic [OUT_DATA_W-1:0] d);
        t_fifo_report e;
        if (report_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, d);
            mismatch_count++;
        end else begin
            e = report_q.pop_front();
            compare_field("status",     e.status,    d[1:0]);
            compare_field("found",      e.found,     d[2]);
            compare_field("found_slot", e.slot,      d[5:3]);
            compare_field("head_value", e.head_word, d[37:6]);
            compare_field("tail_value", e.tail_word, d[69:38]);
            compare_field("count",      e.count,     d[73:70]);
            compare_field("is_empty",   e.empty,     d[74]);
            compare_field("is_full",    e.full,      d[75]);
            compare_field("padding",    32'd0,       d[79:76]);
        end
    endtask

    // Receiver: random stall before each result, plus one long hold-off on request.
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_len) @(posedge i_clk);
                hold_off_len = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_report(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Extremes, a small pool that makes duplicates, or any word.
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if (r < 50) return 32'($urandom_range(0, 7));
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_key();
        logic [2:0] idx;
        if (ring_fill != 4'd0 && $urandom_range(0, 99) < 60) begin
            idx = ring_head;
            repeat ($urandom_range(0, ring_fill - 1)) idx = next_slot(idx);
            return ring_word[idx];
        end
        return pick_word();
    endfunction

    // Search, dequeue and unknown code on the queue just out of reset.
    task automatic test_empty_queue();
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_DEQ, 32'hffff_ffff);
        send_item(OP_UNKNOWN, 32'h8000_0000);
    endtask

    // Fill to the brim, extremes first, overflow, then search front, rear, miss.
    task automatic test_fill_to_full();
        send_item(OP_ENQ, 32'h8000_0000);
        send_item(OP_ENQ, 32'h7fff_ffff);
        send_item(OP_ENQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'hffff_ffff);
        send_item(OP_ENQ, 32'h0000_0001);
        send_item(OP_ENQ, 32'h5555_5555);
        send_item(OP_ENQ, 32'haaaa_aaaa);
        send_item(OP_ENQ, 32'h1234_5678);
        send_item(OP_ENQ, 32'hdead_beef);
        send_item(OP_SEARCH, 32'h8000_0000);
        send_item(OP_SEARCH, 32'h1234_5678);
        send_item(OP_SEARCH, 32'h7654_3210);
        send_item(OP_UNKNOWN, 32'h7fff_ffff);
    endtask

    // Drain part way, wrap the rear past the last slot, and check that a
    // duplicated key reports the match nearest the front.
    task automatic test_wrap_and_first_match();
        repeat (6) send_item(OP_DEQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'h0000_002a);
        send_item(OP_ENQ, 32'h0000_002a);
        send_item(OP_SEARCH, 32'h0000_002a);
        send_item(OP_SEARCH, 32'h1234_5678);
    endtask

    // The receiver holds off while the sender keeps offering back to back.
    task automatic test_output_backpressure();
        no_idle      = 1'b1;
        hold_off_len = 400;
        repeat (40) begin
            case ($urandom_range(0, 2))
                0:       send_item(OP_ENQ, pick_word());
                1:       send_item(OP_DEQ, pick_word());
                default: send_item(OP_SEARCH, pick_key());
            endcase
        end
        no_idle = 1'b0;
    endtask

    task automatic run_traffic(input int n, input int enq_pct, input int deq_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(OP_UNKNOWN, pick_word());
            else if (r < 3 + enq_pct)
                send_item(OP_ENQ, pick_word());
            else if (r < 3 + enq_pct + deq_pct)
                send_item(OP_DEQ, pick_word());
            else
                send_item(OP_SEARCH, pick_key());
        end
    endtask

    // Phases lean toward filling, balance, draining; one runs without gaps.
    task automatic test_random_traffic();
        run_traffic(200, 65, 15);
        run_traffic(300, 35, 30);
        no_idle = 1'b1;
        run_traffic(150, 40, 30);
        no_idle = 1'b0;
        run_traffic(300, 20, 50);
        run_traffic(300, 45, 25);
        run_traffic(150, 30, 30);
    endtask

    initial begin
        ring_head = 3'd0;
        ring_tail = 3'(DEPTH - 1);
        ring_fill = 4'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_to_full();
        test_wrap_and_first_match();
        test_output_backpressure();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (mismatch_count == 0 && report_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
